FILE: design/baro_sequence_and_compensation_macros.svh
// Assertion macros used by the barometer compensation top level.
// Expects clk and rst_n in the scope of each use.
`ifndef BARO_SEQUENCE_AND_COMPENSATION_MACROS_SVH
`define BARO_SEQUENCE_AND_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BSC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BSC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bsc_pkg.sv
// Shared types, constants and microcode ROM for the barometer compensation block.
// No dependencies; used by bsc_sequencer, bsc_datapath and the top level.
package bsc_pkg;

  localparam int STAGE_W = 3;
  localparam int STEP_W  = 4;
  localparam int COEF_W  = 16;
  localparam int WORD_W  = 24;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;
  localparam int CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] CFG_SENS        = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_OFFSET      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SENS_TEMP   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_OFFSET_TEMP = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_REF_TEMP    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_TEMP_SENS   = 3'd5;

  localparam logic signed [19:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [19:0] TEMP_COLD = -20'sd1500;

  localparam logic [STEP_W-1:0] STEP_APPLY = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PMUL  = 4'd10;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_temp;
    logic [COEF_W-1:0] offset_temp;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_sens;
  } coef_t;

  typedef enum logic [1:0] {MA_DT, MA_D, MA_WORD} mul_a_t;

  typedef enum logic [2:0] {
    MB_C6, MB_C4, MB_C3, MB_DT, MB_D, MB_SLO, MB_SHI
  } mul_b_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_DT, OP_TEMP, OP_OFF, OP_SENS, OP_T2, OP_OFF2, OP_COLD,
    OP_APPLY, OP_LO, OP_FULL, OP_PRES
  } uop_t;

  typedef enum logic [1:0] {JC_NONE, JC_WARM, JC_MILD} jcond_t;

  typedef struct packed {
    mul_a_t             ma;
    mul_b_t             mb;
    uop_t               op;
    jcond_t             jc;
    logic [STEP_W-1:0]  target;
    logic               last;
  } uword_t;

  typedef struct packed {
    logic warm;
    logic mild;
  } dp_flags_t;

  function automatic uword_t uw(input mul_a_t ma, input mul_b_t mb, input uop_t op,
                                input jcond_t jc, input logic [STEP_W-1:0] target,
                                input logic last);
    uword_t w;
    w.ma     = ma;
    w.mb     = mb;
    w.op     = op;
    w.jc     = jc;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  localparam uword_t UW_NOP = '{ma: MA_DT, mb: MB_DT, op: OP_NOP, jc: JC_NONE,
                                target: '0, last: 1'b0};

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
    uword_t w;
    case (addr)
      4'd0:  w = uw(MA_DT,   MB_DT,  OP_DT,    JC_NONE, '0,         1'b0);
      4'd1:  w = uw(MA_DT,   MB_C6,  OP_NOP,   JC_NONE, '0,         1'b0);
      4'd2:  w = uw(MA_DT,   MB_C4,  OP_TEMP,  JC_NONE, '0,         1'b0);
      4'd3:  w = uw(MA_DT,   MB_C3,  OP_OFF,   JC_NONE, '0,         1'b0);
      4'd4:  w = uw(MA_DT,   MB_DT,  OP_SENS,  JC_WARM, STEP_PMUL,  1'b0);
      4'd5:  w = uw(MA_D,    MB_D,   OP_T2,    JC_NONE, '0,         1'b0);
      4'd6:  w = uw(MA_DT,   MB_DT,  OP_OFF2,  JC_MILD, STEP_APPLY, 1'b0);
      4'd7:  w = uw(MA_D,    MB_D,   OP_NOP,   JC_NONE, '0,         1'b0);
      4'd8:  w = uw(MA_DT,   MB_DT,  OP_COLD,  JC_NONE, '0,         1'b0);
      4'd9:  w = uw(MA_DT,   MB_DT,  OP_APPLY, JC_NONE, '0,         1'b0);
      4'd10: w = uw(MA_WORD, MB_SLO, OP_NOP,   JC_NONE, '0,         1'b0);
      4'd11: w = uw(MA_WORD, MB_SHI, OP_LO,    JC_NONE, '0,         1'b0);
      4'd12: w = uw(MA_DT,   MB_DT,  OP_FULL,  JC_NONE, '0,         1'b0);
      4'd13: w = uw(MA_DT,   MB_DT,  OP_PRES,  JC_NONE, '0,         1'b1);
      default: w = uw(MA_DT, MB_DT,  OP_NOP,   JC_NONE, '0,         1'b1);
    endcase
    return w;
  endfunction

endpackage

FILE: design/baro_sequence_and_compensation.sv
// Barometer read sequencing and second-order temperature compensation, top level.
// Depends on bsc_pkg, bsc_sequencer, bsc_datapath and the assertion macro header.
//
// Usage: each input beat carries one 24-bit ADC word. A stage counter marks the first
// word of a round as raw temperature (stored, result_valid 0, zero fields) and the next
// PRESSURE_READS words as raw pressures, each giving compensated temperature and
// pressure. next_conversion names the conversion to start after the beat.
// Calibration words are to be written by the user on the cfg port (index 0 to 5) only
// while the block is idle; the block itself does not enforce this. A temperature beat
// passes from acceptance through the done state into the output register. A pressure
// beat runs a 9, 12 or 14 step microprogram (at or above 20 C, between -15 C and 20 C,
// below -15 C), bound by the one shared 25x25 multiplier, and its result then passes
// through the done state to the output register; no new beat is taken unless idle.
// A finished result waits in the output register while out_stall is high; the block
// keeps taking and working on the next beat and holds that one only at its end.
// Reset (synchronous, active low) clears the stage counter, the calibration words and
// the output valid; the next beat after reset is a temperature.
module baro_sequence_and_compensation #(
  parameter int PRESSURE_READS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bsc_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bsc_pkg::WORD_W-1:0]          in_adc_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_result_valid,
  output logic signed [bsc_pkg::TEMP_W-1:0]   out_temperature_centi,
  output logic signed [bsc_pkg::PRES_W-1:0]   out_pressure_pa,
  output logic                                out_next_conversion
);
  import bsc_pkg::*;
  `include "baro_sequence_and_compensation_macros.svh"

  localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(PRESSURE_READS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  coef_t              coef_r;
  logic               press_r;
  logic               next_r;
  logic               out_valid_r, out_valid_nxt;
  logic               res_valid_r;
  logic signed [TEMP_W-1:0] res_temp_r;
  logic signed [PRES_W-1:0] res_pres_r;
  logic               res_next_r;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               seq_start;
  logic               seq_done;
  uword_t             ctrl;
  dp_flags_t          flags;
  logic signed [TEMP_W-1:0] dp_temp;
  logic signed [PRES_W-1:0] dp_pres;

  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_DONE) && out_free;
  assign seq_start = in_acc && (stage_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (stage_r == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (seq_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    stage_nxt = stage_r;
    if (in_acc) begin
      if (stage_r == '0) begin
        stage_nxt = 3'd1;
      end else if (stage_r >= STAGE_LAST) begin
        stage_nxt = '0;
      end else begin
        stage_nxt = stage_r + 1'b1;
      end
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
      coef_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SENS:        coef_r.sens        <= cfg_wdata;
          CFG_OFFSET:      coef_r.offset      <= cfg_wdata;
          CFG_SENS_TEMP:   coef_r.sens_temp   <= cfg_wdata;
          CFG_OFFSET_TEMP: coef_r.offset_temp <= cfg_wdata;
          CFG_REF_TEMP:    coef_r.ref_temp    <= cfg_wdata;
          CFG_TEMP_SENS:   coef_r.temp_sens   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      press_r <= stage_r != '0;
      next_r  <= (stage_r != '0) && (stage_r >= STAGE_LAST);
    end
    if (out_load) begin
      res_valid_r <= press_r;
      res_temp_r  <= press_r ? dp_temp : '0;
      res_pres_r  <= press_r ? dp_pres : '0;
      res_next_r  <= next_r;
    end
  end

  bsc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .flags (flags),
    .ctrl  (ctrl),
    .done  (seq_done)
  );

  bsc_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .coef      (coef_r),
    .load_temp (in_acc && (stage_r == '0)),
    .load_word (in_acc),
    .adc_word  (in_adc_word),
    .flags     (flags),
    .temp_out  (dp_temp),
    .pres_out  (dp_pres)
  );

  assign out_valid             = out_valid_r;
  assign out_result_valid      = res_valid_r;
  assign out_temperature_centi = res_temp_r;
  assign out_pressure_pa       = res_pres_r;
  assign out_next_conversion   = res_next_r;

  `BSC_ASSERT_IMP(a_stage_range, 1'b1, stage_r <= STAGE_LAST, "stage beyond last read")
  `BSC_ASSERT_NXT(a_temp_then_first, in_acc && (stage_r == '0), stage_r == 3'd1,
                  "temperature beat did not advance to first pressure")
  `BSC_ASSERT_NXT(a_pressure_runs, in_acc && (stage_r != '0), state_r == S_RUN,
                  "pressure beat did not start the microprogram")
  `BSC_ASSERT_IMP(a_done_in_run, seq_done, state_r == S_RUN,
                  "microprogram finished outside run state")
  `BSC_ASSERT_IMP(a_temp_beat_zero, out_valid && !out_result_valid,
                  out_pressure_pa == '0 && out_temperature_centi == '0 && !out_next_conversion,
                  "temperature beat result not zero")

endmodule

FILE: design/bsc_sequencer.sv
// Step counter and microcode ROM lookup with conditional jumps.
// Depends on bsc_pkg for the control word and the ROM contents.
module bsc_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  bsc_pkg::dp_flags_t flags,
  output bsc_pkg::uword_t    ctrl,
  output logic               done
);
  import bsc_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  uword_t            cur;
  logic              taken;

  always_comb begin
    cur = ucode_rom(step_r);
    case (cur.jc)
      JC_NONE: taken = 1'b0;
      JC_WARM: taken = flags.warm;
      JC_MILD: taken = flags.mild;
      default: taken = 1'b0;
    endcase
    ctrl     = run_r ? cur : UW_NOP;
    done     = run_r && cur.last;
    run_nxt  = start || (run_r && !cur.last);
    step_nxt = step_r;
    if (start) begin
      step_nxt = '0;
    end else if (run_r && !cur.last) begin
      step_nxt = taken ? cur.target : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/bsc_datapath.sv
// Compensation datapath: one shared registered 25x25 multiplier and working registers.
// Depends on bsc_pkg; driven one control word per cycle by bsc_sequencer.
module bsc_datapath (
  input  logic                                 clk,
  input  bsc_pkg::uword_t                      ctrl,
  input  bsc_pkg::coef_t                       coef,
  input  logic                                 load_temp,
  input  logic                                 load_word,
  input  logic [bsc_pkg::WORD_W-1:0]           adc_word,
  output bsc_pkg::dp_flags_t                   flags,
  output logic signed [bsc_pkg::TEMP_W-1:0]    temp_out,
  output logic signed [bsc_pkg::PRES_W-1:0]    pres_out
);
  import bsc_pkg::*;

  logic [WORD_W-1:0]  raw_temp_r;
  logic [WORD_W-1:0]  word_r;
  logic signed [24:0] dt_r;
  logic signed [19:0] temp_r;
  logic signed [19:0] d_r;
  logic               cold_r;
  logic signed [41:0] off_r;
  logic signed [39:0] sens_r;
  logic signed [39:0] off2_r;
  logic signed [39:0] sens2_r;
  logic signed [63:0] acc_r;
  logic signed [49:0] prod_r;
  logic signed [31:0] pres_r;

  logic signed [24:0] a_op;
  logic signed [24:0] b_op;
  logic signed [49:0] prod_nxt;
  logic [39:0]        p40;
  logic [39:0]        five_p;
  logic [39:0]        eleven_p;
  logic signed [43:0] pdiff;

  always_comb begin
    case (ctrl.ma)
      MA_DT:   a_op = dt_r;
      MA_D:    a_op = {{5{d_r[19]}}, d_r};
      MA_WORD: a_op = {1'b0, word_r};
      default: a_op = '0;
    endcase
    case (ctrl.mb)
      MB_C6:   b_op = {9'b0, coef.temp_sens};
      MB_C4:   b_op = {9'b0, coef.offset_temp};
      MB_C3:   b_op = {9'b0, coef.sens_temp};
      MB_DT:   b_op = dt_r;
      MB_D:    b_op = {{5{d_r[19]}}, d_r};
      MB_SLO:  b_op = {5'b0, sens_r[19:0]};
      MB_SHI:  b_op = {{5{sens_r[39]}}, sens_r[39:20]};
      default: b_op = '0;
    endcase
    prod_nxt = a_op * b_op;
    p40      = prod_r[39:0];
    five_p   = p40 + {p40[37:0], 2'b00};
    eleven_p = p40 + {p40[38:0], 1'b0} + {p40[36:0], 3'b000};
    pdiff    = {acc_r[63], acc_r[63:21]} - {{2{off_r[41]}}, off_r};
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (load_temp) begin
      raw_temp_r <= adc_word;
    end
    if (load_word) begin
      word_r <= adc_word;
    end
    case (ctrl.op)
      OP_NOP: begin
      end
      OP_DT: begin
        dt_r <= $signed({1'b0, raw_temp_r}) - $signed({1'b0, coef.ref_temp, 8'b0});
      end
      OP_TEMP: begin
        temp_r <= $signed(prod_r[42:23]) + TEMP_REF;
      end
      OP_OFF: begin
        off_r <= $signed({10'b0, coef.offset, 16'b0}) + $signed(prod_r[48:7]);
      end
      OP_SENS: begin
        sens_r <= $signed({9'b0, coef.sens, 15'b0}) + $signed(prod_r[47:8]);
        d_r    <= temp_r - TEMP_REF;
      end
      OP_T2: begin
        temp_r <= temp_r - $signed({prod_r[49], prod_r[49:31]});
        d_r    <= temp_r - TEMP_COLD;
        cold_r <= temp_r < TEMP_COLD;
      end
      OP_OFF2: begin
        off2_r  <= $signed({1'b0, five_p[39:1]});
        sens2_r <= $signed({2'b0, five_p[39:2]});
      end
      OP_COLD: begin
        off2_r  <= off2_r + $signed({p40[36:0], 3'b000}) - $signed(p40);
        sens2_r <= sens2_r + $signed({1'b0, eleven_p[39:1]});
      end
      OP_APPLY: begin
        off_r  <= off_r - {{2{off2_r[39]}}, off2_r};
        sens_r <= sens_r - sens2_r;
      end
      OP_LO: begin
        acc_r <= {{14{prod_r[49]}}, prod_r};
      end
      OP_FULL: begin
        acc_r <= acc_r + $signed({prod_r[43:0], 20'b0});
      end
      OP_PRES: begin
        pres_r <= {{3{pdiff[43]}}, pdiff[43:15]};
      end
      default: begin
      end
    endcase
  end

  assign flags.warm = temp_r >= TEMP_REF;
  assign flags.mild = !cold_r;
  assign temp_out   = temp_r[TEMP_W-1:0];
  assign pres_out   = pres_r;

endmodule

FILE: tb/tb_top.sv
// Testbench for baro_sequence_and_compensation: drives rounds of raw ADC words
// under several calibration sets and random pacing, and checks each beat's
// result against an in-bench compensation predictor. Needs bsc_pkg and the RTL.
module tb_top;
  import bsc_pkg::*;

  localparam int ROUND_PRESSURES = 4;
  localparam int ITEMS_PER_PHASE = 246;
  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_CAP = 100;

  localparam logic [CIDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_7 = 3'd7;

  localparam logic NEXT_PRESSURE    = 1'b0;
  localparam logic NEXT_TEMPERATURE = 1'b1;

  localparam logic [WORD_W-1:0] WORD_MAX = '1;
  localparam logic [WORD_W-1:0] WORD_MID = 24'h800000;
  localparam logic [WORD_W-1:0] PRES_TYPICAL = 24'd9085466;

  localparam coef_t TYPICAL_CAL = '{sens: 16'd40127, offset: 16'd36924,
                                    sens_temp: 16'd23317, offset_temp: 16'd23282,
                                    ref_temp: 16'd33464, temp_sens: 16'd28312};

  typedef struct packed {
    logic                      result_valid;
    logic signed [TEMP_W-1:0]  temp_centi;
    logic signed [PRES_W-1:0]  pressure;
    logic                      next_conv;
  } reading_t;

  typedef enum logic [1:0] {PACE_MIXED_A, PACE_MIXED_B, PACE_FULL} pace_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CIDX_W-1:0]         cfg_index = CFG_SENS;
  logic [COEF_W-1:0]         cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [WORD_W-1:0]         in_adc_word = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_result_valid;
  logic signed [TEMP_W-1:0]  out_temperature_centi;
  logic signed [PRES_W-1:0]  out_pressure_pa;
  logic                      out_next_conversion;

  coef_t               cal;
  logic [STAGE_W-1:0]  stage;
  logic [WORD_W-1:0]   raw_temp;
  reading_t            pending_readings[$];
  int                  mismatch_count = 0;
  int                  quiet_cycles = 0;
  pace_t               pace = PACE_MIXED_A;

  baro_sequence_and_compensation #(
    .PRESSURE_READS(ROUND_PRESSURES)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_adc_word           (in_adc_word),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_valid      (out_result_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_pa       (out_pressure_pa),
    .out_next_conversion   (out_next_conversion)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic reading_t predict_reading(input logic [WORD_W-1:0] word);
    reading_t r;
    longint   rt, pw, c1, c2, c3, c4, c5, c6;
    longint   dt, temp, off, sens, t2, off2, sens2, dd, p;
    r = '0;
    if (stage == '0) begin
      raw_temp = word;
      stage = STAGE_W'(1);
      r.next_conv = NEXT_PRESSURE;
      return r;
    end
    rt = longint'(raw_temp);
    pw = longint'(word);
    c1 = longint'(cal.sens);
    c2 = longint'(cal.offset);
    c3 = longint'(cal.sens_temp);
    c4 = longint'(cal.offset_temp);
    c5 = longint'(cal.ref_temp);
    c6 = longint'(cal.temp_sens);
    dt = rt - (c5 <<< 8);
    temp = longint'(TEMP_REF) + ((dt * c6) >>> 23);
    off = (c2 <<< 16) + ((c4 * dt) >>> 7);
    sens = (c1 <<< 15) + ((c3 * dt) >>> 8);
    if (temp < longint'(TEMP_REF)) begin
      t2 = (dt * dt) >>> 31;
      dd = temp - longint'(TEMP_REF);
      off2 = (5 * dd * dd) >>> 1;
      sens2 = off2 >>> 1;
      if (temp < longint'(TEMP_COLD)) begin
        dd = temp - longint'(TEMP_COLD);
        off2 += 7 * dd * dd;
        sens2 += (11 * dd * dd) >>> 1;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
    end
    p = (((pw * sens) >>> 21) - off) >>> 15;
    if (stage >= ROUND_PRESSURES) begin
      stage = '0;
      r.next_conv = NEXT_TEMPERATURE;
    end else begin
      stage = stage + 1'b1;
      r.next_conv = NEXT_PRESSURE;
    end
    r.result_valid = 1'b1;
    r.temp_centi = temp[TEMP_W-1:0];
    r.pressure = p[PRES_W-1:0];
    return r;
  endfunction

  function automatic void apply_cfg(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    case (idx)
      CFG_SENS:        cal.sens = val;
      CFG_OFFSET:      cal.offset = val;
      CFG_SENS_TEMP:   cal.sens_temp = val;
      CFG_OFFSET_TEMP: cal.offset_temp = val;
      CFG_REF_TEMP:    cal.ref_temp = val;
      CFG_TEMP_SENS:   cal.temp_sens = val;
      default: ;
    endcase
  endfunction

  function automatic int sender_idle_pct();
    case (pace)
      PACE_MIXED_A: return 37;
      PACE_MIXED_B: return 46;
      default:      return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (pace)
      PACE_MIXED_A: return 46;
      PACE_MIXED_B: return 37;
      default:      return 0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_raw_temp();
    int base, spread, val;
    base = int'(cal.ref_temp) * 256;
    case ($urandom_range(3))
      0: return WORD_W'($urandom);
      1: return $urandom_range(1) ? WORD_MAX : '0;
      default: begin
        spread = 1 << (17 + 3 * $urandom_range(2));
        val = base - spread + int'($urandom_range(2 * spread));
        if (val < 0) val = 0;
        if (val > int'(WORD_MAX)) val = int'(WORD_MAX);
        return val[WORD_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_pressure();
    case ($urandom_range(9))
      0:       return '0;
      1:       return WORD_MAX;
      2, 3, 4: return WORD_W'($urandom_range(10000000, 500000));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic send_word(input logic [WORD_W-1:0] word);
    if ($urandom_range(99) < sender_idle_pct()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct());
    end
    in_valid <= 1'b1;
    in_adc_word <= word;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(predict_reading(word));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_cfg(idx, val);
  endtask

  task automatic load_calibration(input coef_t c);
    cfg_put(CFG_SENS, c.sens);
    cfg_put(CFG_OFFSET, c.offset);
    cfg_put(CFG_SENS_TEMP, c.sens_temp);
    cfg_put(CFG_OFFSET_TEMP, c.offset_temp);
    cfg_put(CFG_REF_TEMP, c.ref_temp);
    cfg_put(CFG_TEMP_SENS, c.temp_sens);
    cfg_we <= 1'b0;
  endtask

  task automatic send_round(input logic [WORD_W-1:0] t_word);
    send_word(t_word);
    send_word('0);
    send_word(WORD_MAX);
    send_word(WORD_MID);
    send_word(PRES_TYPICAL);
  endtask

  // Reset calibration is all zero, so the first round runs on zero words.
  task automatic test_reset_calibration();
    send_round(PRES_TYPICAL);
  endtask

  task automatic test_spare_indexes();
    wait_drained();
    cfg_put(CFG_SPARE_6, 16'hFFFF);
    cfg_put(CFG_SPARE_7, 16'hA5A5);
    cfg_we <= 1'b0;
    send_round(WORD_MAX);
  endtask

  // Cold (below -15 C), mild and warm rounds, with negative and positive dT.
  task automatic test_temperature_bands();
    wait_drained();
    load_calibration(TYPICAL_CAL);
    send_round('0);
    send_round(24'd8077636);
    send_round(WORD_MAX);
  endtask

  task automatic test_random_rounds();
    coef_t c;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       c = TYPICAL_CAL;
        1:       c = '0;
        2:       c = '1;
        default: c = {$urandom, $urandom, $urandom};
      endcase
      wait_drained();
      load_calibration(c);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n < ITEMS_PER_PHASE / 3) pace = PACE_MIXED_A;
        else if (n < 2 * ITEMS_PER_PHASE / 3) pace = PACE_MIXED_B;
        else pace = PACE_FULL;
        send_word(stage == '0 ? pick_raw_temp() : pick_pressure());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct());
    end
  end

  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("result beat with no reading pending");
      end else begin
        want = pending_readings.pop_front();
        if (out_result_valid !== want.result_valid)
          report_mismatch($sformatf("result_valid got %0b expected %0b",
                                    out_result_valid, want.result_valid));
        if (out_temperature_centi !== want.temp_centi)
          report_mismatch($sformatf("temperature_centi got %0d expected %0d",
                                    out_temperature_centi, want.temp_centi));
        if (out_pressure_pa !== want.pressure)
          report_mismatch($sformatf("pressure_pa got %0d expected %0d",
                                    out_pressure_pa, want.pressure));
        if (out_next_conversion !== want.next_conv)
          report_mismatch($sformatf("next_conversion got %0b expected %0b",
                                    out_next_conversion, want.next_conv));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    cal = '0;
    stage = '0;
    raw_temp = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_calibration();
    test_spare_indexes();
    test_temperature_bands();
    test_random_rounds();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: baro_sequence_and_compensation.f
+incdir+design
design/bsc_pkg.sv
design/bsc_sequencer.sv
design/bsc_datapath.sv
design/baro_sequence_and_compensation.sv
tb/tb_top.sv
